>>> rtl/rgbhsv_pkg.sv
// Shared types, widths and constants for the RGB to HSV converter.
package rgbhsv_pkg;

    localparam int COMP_W  = 32;
    // Hue numerator and denominator stay below 2^35.
    localparam int NUM_W   = 36;
    // Quotient bits produced: 32 fraction bits plus one guard for the full-scale case.
    localparam int QUO_W   = 33;
    localparam int DATA_W  = 96;
    // One divider cell per fraction bit; the integer bit is taken in the input stage.
    localparam int CELLS   = 32;

    // Hue sector, first match in red, green, blue order.
    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } sector_t;

    // Word carried down the divider chain for one division.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] den;
        logic [NUM_W-1:0] num;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    // Word handed from cell to cell.
    typedef struct packed {
        logic             valid;
        div_lane_t        hue;
        div_lane_t        sat;
        logic [COMP_W-1:0] bright;
    } cell_word_t;

    // One restoring division step.
    function automatic div_lane_t div_step(input div_lane_t a);
        div_lane_t        o;
        logic [NUM_W:0]   sh;
        sh = {a.rem, 1'b0};
        o  = a;
        if (sh >= {1'b0, a.den})
        begin
            o.rem = NUM_W'(sh - {1'b0, a.den});
            o.quo = {a.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = sh[NUM_W-1:0];
            o.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> rtl/rgbhsv_front.sv
// Input stage: max, min, sector and the two division operands.
module rgbhsv_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rgbhsv_pkg::COMP_W-1:0] red,
    input  logic [rgbhsv_pkg::COMP_W-1:0] green,
    input  logic [rgbhsv_pkg::COMP_W-1:0] blue,
    output rgbhsv_pkg::cell_word_t      out_word
);

    logic [rgbhsv_pkg::COMP_W-1:0] mx, mn;
    logic [rgbhsv_pkg::NUM_W-1:0]  delta, num, den;
    rgbhsv_pkg::sector_t           sec;
    rgbhsv_pkg::cell_word_t        word_next, word_reg;
    logic                          active;

    // Find extremes and sector.
    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        if (red == mx)        sec = rgbhsv_pkg::SEC_RED;
        else if (green == mx) sec = rgbhsv_pkg::SEC_GREEN;
        else                  sec = rgbhsv_pkg::SEC_BLUE;
        delta  = rgbhsv_pkg::NUM_W'(mx - mn);
        active = (delta != '0);
        den    = (delta << 2) + (delta << 1);
        case (sec)
            rgbhsv_pkg::SEC_RED:
            begin
                num = rgbhsv_pkg::NUM_W'({4'b0, green}) - rgbhsv_pkg::NUM_W'({4'b0, blue});
                if (green < blue) num = num + den;
            end
            rgbhsv_pkg::SEC_GREEN:
                num = (delta << 1) + rgbhsv_pkg::NUM_W'({4'b0, blue})
                      - rgbhsv_pkg::NUM_W'({4'b0, red});
            default:
                num = (delta << 2) + rgbhsv_pkg::NUM_W'({4'b0, red})
                      - rgbhsv_pkg::NUM_W'({4'b0, green});
        endcase
    end

    // Build the lane words; grey and black divide 0 by 1.
    always_comb
    begin
        word_next           = '0;
        word_next.valid     = in_valid;
        word_next.bright    = mx;
        word_next.hue.num   = active ? num : '0;
        word_next.hue.den   = active ? den : rgbhsv_pkg::NUM_W'(1);
        word_next.hue.rem   = active ? num : '0;
        word_next.sat.num   = active ? delta : '0;
        word_next.sat.den   = active ? rgbhsv_pkg::NUM_W'({4'b0, mx}) : rgbhsv_pkg::NUM_W'(1);
        word_next.sat.rem   = word_next.sat.num;
        // Take the integer quotient bit: saturation is exactly one when min is zero.
        if (word_next.sat.num >= word_next.sat.den)
        begin
            word_next.sat.rem = word_next.sat.num - word_next.sat.den;
            word_next.sat.quo = rgbhsv_pkg::QUO_W'(1);
        end
    end

    // Capture when the chain advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else if (en)
            word_reg <= word_next;
    end

    assign out_word = word_reg;

endmodule

>>> rtl/rgbhsv_cell.sv
// One divider cell: a quotient bit for hue and saturation each cycle that en is high.
module rgbhsv_cell
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  rgbhsv_pkg::cell_word_t in_word,
    output rgbhsv_pkg::cell_word_t out_word
);

    rgbhsv_pkg::cell_word_t word_next, word_reg;

    // Advance both lanes by one bit.
    always_comb
    begin
        word_next     = in_word;
        word_next.hue = rgbhsv_pkg::div_step(in_word.hue);
        word_next.sat = rgbhsv_pkg::div_step(in_word.sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else if (en)
            word_reg <= word_next;
    end

    assign out_word = word_reg;

endmodule

>>> rtl/rgbhsv_round.sv
// Final stage: n*2^32 = q*d + r turned into round(n*(2^32-1)/d), ties to even.
module rgbhsv_round
(
    input  logic [rgbhsv_pkg::NUM_W-1:0]  num,
    input  logic [rgbhsv_pkg::NUM_W-1:0]  den,
    input  logic [rgbhsv_pkg::NUM_W-1:0]  rem,
    input  logic [rgbhsv_pkg::QUO_W-1:0]  quo,
    output logic [rgbhsv_pkg::COMP_W-1:0] result
);

    logic [rgbhsv_pkg::NUM_W:0]   r;
    logic [rgbhsv_pkg::NUM_W+1:0] r2;
    logic [rgbhsv_pkg::QUO_W:0]   q;

    // Subtract n from the remainder, borrow once, round, clamp.
    always_comb
    begin
        q = {1'b0, quo};
        if (rem >= num)
            r = {1'b0, rem - num};
        else
        begin
            r = {1'b0, rem} + {1'b0, den} - {1'b0, num};
            q = q - (rgbhsv_pkg::QUO_W+1)'(1);
        end
        r2 = {r, 1'b0};
        if (r2 > {2'b0, den} || (r2 == {2'b0, den} && q[0]))
            q = q + (rgbhsv_pkg::QUO_W+1)'(1);
        if (q > {2'b0, {rgbhsv_pkg::COMP_W{1'b1}}})
            result = '1;
        else
            result = q[rgbhsv_pkg::COMP_W-1:0];
    end

endmodule

>>> rtl/rgb_to_hsv_converter_top.sv
// Top level of the RGB to HSV converter: input stage, divider chain, output register.
//
// Usage:
//   s_axis carries one pixel per word: tdata = {blue, green, red}, red lowest.
//   m_axis returns one word per pixel: tdata = {brightness, saturation, hue}.
//   Hue and saturation come from a chain of CELLS identical divider cells,
//   each producing one quotient bit of both divisions per cycle unless stalled.
// Path: the accepting edge loads the input stage; the word then passes
//   through each cell register in order and into the output register,
//   which drives m_axis_tvalid.
// Throughput: one pixel per clock unless stalled; the whole chain advances together.
// Stall: when m_axis_tready is low and the output holds a word, the whole
//   chain freezes and s_axis_tready drops; bubbles in the chain are not
//   squeezed out, so words are never lost, repeated or reordered.
// Reset: rst_n clears all valid flags; no pixel is in flight after reset.
// No configuration registers.
module rgb_to_hsv_converter_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // red [31:0], green [63:32], blue [95:64]
    input  logic [rgbhsv_pkg::DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // hue [31:0], saturation [63:32], brightness [95:64]
    output logic [rgbhsv_pkg::DATA_W-1:0]  m_axis_tdata
);

    localparam int CELLS = rgbhsv_pkg::CELLS;

    rgbhsv_pkg::cell_word_t chain [CELLS+1];
    logic                   en;
    logic                   out_valid_reg;
    logic [rgbhsv_pkg::DATA_W-1:0] out_data_reg;
    logic [rgbhsv_pkg::COMP_W-1:0] hue_w, sat_w;

    // Advance when the output slot is free or being drained.
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    rgbhsv_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .red      (s_axis_tdata[31:0]),
        .green    (s_axis_tdata[63:32]),
        .blue     (s_axis_tdata[95:64]),
        .out_word (chain[0])
    );

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        rgbhsv_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_word  (chain[i]),
            .out_word (chain[i+1])
        );
    end

    rgbhsv_round u_round_hue
    (
        .num    (chain[CELLS].hue.num),
        .den    (chain[CELLS].hue.den),
        .rem    (chain[CELLS].hue.rem),
        .quo    (chain[CELLS].hue.quo),
        .result (hue_w)
    );

    rgbhsv_round u_round_sat
    (
        .num    (chain[CELLS].sat.num),
        .den    (chain[CELLS].sat.den),
        .rem    (chain[CELLS].sat.rem),
        .quo    (chain[CELLS].sat.quo),
        .result (sat_w)
    );

    // Hold the result word until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= chain[CELLS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {chain[CELLS].bright, sat_w, hue_w};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A stalled output keeps the whole chain frozen.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(chain[CELLS].valid))
        else $error("chain moved during output stall");
    // Input is refused only while a result waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused without stall");
    // A black pixel gives zero hue and zero saturation.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[95:64] == '0) |-> (m_axis_tdata[63:0] == '0))
        else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

>>> bench/rgb_to_hsv_converter_top_tb.sv
// Testbench for the RGB to HSV converter: random and directed pixels checked against a predictor.
`timescale 1ns / 1ps

class hsv_scoreboard;
    typedef struct packed {
        logic [31:0] hue;
        logic [31:0] sat;
        logic [31:0] bright;
    } hsv_t;

    hsv_t pending[$];
    int   mismatches;
    int   orphans;

    function new();
        mismatches = 0;
        orphans = 0;
    endfunction

    // round(n * 0xFFFFFFFF / d), ties to even
    static function logic [31:0] scale_ratio(logic [63:0] n, logic [63:0] d);
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] r;
        prod = {64'd0, n} * 128'h0FFFFFFFF;
        q = prod / d;
        r = prod % d;
        if (2 * r > d || (2 * r == d && q[0]))
            q = q + 1;
        if (q > 128'h0FFFFFFFF)
            q = 128'h0FFFFFFFF;
        return q[31:0];
    endfunction

    // Note an accepted pixel and predict its HSV word
    function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
        hsv_t        e;
        logic [63:0] mx;
        logic [63:0] mn;
        logic [63:0] delta;
        longint      num;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        e.hue = 0;
        e.sat = 0;
        e.bright = mx[31:0];
        if (mx != 0 && delta != 0)
        begin
            e.sat = scale_ratio(delta, mx);
            if (r == mx)
                num = longint'(g) - longint'(b);
            else if (g == mx)
                num = 2 * longint'(delta) + longint'(b) - longint'(r);
            else
                num = 4 * longint'(delta) + longint'(r) - longint'(g);
            if (num < 0)
                num += 6 * longint'(delta);
            e.hue = scale_ratio(num, 6 * delta);
        end
        pending.push_back(e);
    endfunction

    // Check one output word against the oldest prediction
    function void check_word(logic [95:0] d);
        hsv_t e;
        if (pending.size() == 0)
        begin
            orphans++;
            if (mismatches + orphans <= 10)
                $display("unexpected word %h", d);
            return;
        end
        e = pending.pop_front();
        if (d[31:0] !== e.hue || d[63:32] !== e.sat || d[95:64] !== e.bright)
        begin
            mismatches++;
            if (mismatches + orphans <= 10)
                $display("mismatch: exp h=%h s=%h v=%h got h=%h s=%h v=%h",
                         e.hue, e.sat, e.bright, d[31:0], d[63:32], d[95:64]);
        end
    endfunction
endclass

module rgb_to_hsv_converter_top_tb;

    localparam int LIMIT = 400000;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [rgbhsv_pkg::DATA_W-1:0] s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [rgbhsv_pkg::DATA_W-1:0] m_axis_tdata;

    hsv_scoreboard sb;
    int            send_idle;
    int            recv_stall;
    int            cycles;

    rgb_to_hsv_converter_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check output words at the rising edge
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);

    // Randomize receiver stalls at the falling edge
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall);

    // Random component: bias toward extremes and near-ties
    function automatic logic [31:0] rand_comp(logic [31:0] near);
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return near;
            3: return near + $urandom_range(3) - 1;
            4: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // Send one pixel, idling first at random, hold until accepted
    task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, g, r};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_pixel(r, g, b);
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        int          ph;
        sb = new();
        cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: black, white, greys, sector ties, negative hue, pure colors
        send_pixel(0, 0, 0);
        send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(32'h12345678, 32'h12345678, 32'h12345678);
        send_pixel(32'hFFFFFFFF, 0, 0);
        send_pixel(0, 32'hFFFFFFFF, 0);
        send_pixel(0, 0, 32'hFFFFFFFF);
        send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 0);
        send_pixel(0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(32'hFFFFFFFF, 0, 32'hFFFFFFFF);
        send_pixel(100, 10, 50);
        send_pixel(32'hFFFFFFFF, 0, 1);
        send_pixel(1, 0, 0);
        send_pixel(2, 1, 0);
        send_pixel(0, 1, 1);
        send_pixel(3, 1, 2);
        send_pixel(32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFE);
        send_pixel(32'h80000000, 32'h7FFFFFFF, 32'h55555555);
        send_pixel(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);

        // Random phases with different idle and stall mixes
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 77) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 38 : 77) : 0;
            repeat (450)
            begin
                r = rand_comp($urandom);
                g = rand_comp(r);
                b = rand_comp($urandom_range(1) ? r : g);
                send_pixel(r, g, b);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain
        recv_stall = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.orphans == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
